/* rtl/assert_macros.svh */
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/bssw_pkg.sv */
// constants and types of the bilinear slice sampler
package bssw_pkg;

  localparam int MAX_WIDTH       = 512;
  localparam int MAX_HEIGHT      = 512;
  localparam int COORD_FRAC_BITS = 8;

  // fixed field widths
  localparam int COORD_W     = 19;
  localparam int SAMPLE_W    = 16;
  localparam int ADDR_W      = 18;
  localparam int SHADE_W     = 8;
  localparam int GAIN_W      = 24;
  localparam int GAIN_FRAC   = 16;
  localparam int SIZE_REG_W  = 10;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_INDEX_W = 2;

  // store geometry
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int BANK_DEPTH  = STORE_DEPTH / 2;
  localparam int BANK_AW     = STORE_AW - 1;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int WSIZE_W = $clog2(MAX_WIDTH + 1);
  localparam int HSIZE_W = $clog2(MAX_HEIGHT + 1);
  localparam int IPART_W = COORD_W - COORD_FRAC_BITS;

  // weights and datapath widths
  localparam int ONE      = 1 << COORD_FRAC_BITS;
  localparam int WGT_W    = COORD_FRAC_BITS + 1;
  localparam int PROD1_W  = SAMPLE_W + WGT_W + 1;
  localparam int HSUM_W   = PROD1_W + 1;
  localparam int PROD2_W  = HSUM_W + WGT_W + 1;
  localparam int DIFF_W   = PROD2_W + 2;
  localparam int DU_W     = SAMPLE_W + 2 * COORD_FRAC_BITS;
  localparam int SCALE_W  = DU_W + GAIN_W;
  localparam int SHADE_SH = 2 * COORD_FRAC_BITS + GAIN_FRAC;
  localparam int HI_W     = SCALE_W - SHADE_SH;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_IN_USE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT_IN_USE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LOW    = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_GAIN   = 2'd3;

  // commands
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef struct packed {
    logic                cmd;
    logic [ADDR_W-1:0]   waddr;
    logic [SAMPLE_W-1:0] wdata;
    logic [STORE_AW-1:0] addr_a;
    logic [STORE_AW-1:0] addr_b;
    logic [WGT_W-1:0]    wx0;
    logic [WGT_W-1:0]    wx1;
    logic [WGT_W-1:0]    wy0;
    logic [WGT_W-1:0]    wy1;
  } req_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] s00;
    logic signed [SAMPLE_W-1:0] s01;
    logic signed [SAMPLE_W-1:0] s10;
    logic signed [SAMPLE_W-1:0] s11;
    logic [WGT_W-1:0]           wx0;
    logic [WGT_W-1:0]           wx1;
    logic [WGT_W-1:0]           wy0;
    logic [WGT_W-1:0]           wy1;
  } nbr_t;

endpackage

/* rtl/bssw_ram.sv */
// generic single-write, single-read ram with registered read data
module bssw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/bssw_front.sv */
// input register, axis clamping and flat neighbor address generation
`include "assert_macros.svh"

module bssw_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_cmd,
  input  logic [bssw_pkg::ADDR_W-1:0]          in_waddr,
  input  logic [bssw_pkg::SAMPLE_W-1:0]        in_wdata,
  input  logic signed [bssw_pkg::COORD_W-1:0]  in_col,
  input  logic signed [bssw_pkg::COORD_W-1:0]  in_row,
  input  logic [bssw_pkg::WSIZE_W-1:0]         width_eff,
  input  logic [bssw_pkg::HSIZE_W-1:0]         height_eff,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output bssw_pkg::req_t                       out_req
);
  import bssw_pkg::*;

  localparam int CCMP_W = (IPART_W > WSIZE_W) ? IPART_W : WSIZE_W;
  localparam int RCMP_W = (IPART_W > HSIZE_W) ? IPART_W : HSIZE_W;
  localparam int RO_W   = ROW_W + WSIZE_W;

  logic               en1;
  logic               en2;
  logic [IPART_W-1:0] col_ip;
  logic [IPART_W-1:0] row_ip;
  logic [COL_W-1:0]   col_base;
  logic [ROW_W-1:0]   row_base;
  logic [WGT_W-1:0]   col_frac;
  logic [WGT_W-1:0]   row_frac;

  logic                v1;
  logic                cmd1;
  logic [ADDR_W-1:0]   waddr1;
  logic [SAMPLE_W-1:0] wdata1;
  logic [COL_W-1:0]    cx1;
  logic [ROW_W-1:0]    ry1;
  logic [ROW_W-1:0]    ry1n;
  logic [WGT_W-1:0]    wx0_1;
  logic [WGT_W-1:0]    wx1_1;
  logic [WGT_W-1:0]    wy0_1;
  logic [WGT_W-1:0]    wy1_1;

  logic [RO_W-1:0]     row_off_a;
  logic [RO_W-1:0]     row_off_b;
  logic [STORE_AW-1:0] addr_a_next;
  logic [STORE_AW-1:0] addr_b_next;

  assign en2      = !out_valid || out_ready;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  assign col_ip = in_col[COORD_W-1:COORD_FRAC_BITS];
  assign row_ip = in_row[COORD_W-1:COORD_FRAC_BITS];

  // below zero: first cell, no weight on the upper neighbor
  // at or past the last index: last cell, full weight on the upper neighbor
  always_comb begin
    if (in_col[COORD_W-1]) begin
      col_base = '0;
      col_frac = '0;
    end else if (CCMP_W'(col_ip) >= CCMP_W'(width_eff) - CCMP_W'(1)) begin
      col_base = COL_W'(width_eff - WSIZE_W'(2));
      col_frac = WGT_W'(ONE);
    end else begin
      col_base = col_ip[COL_W-1:0];
      col_frac = {1'b0, in_col[COORD_FRAC_BITS-1:0]};
    end
  end

  always_comb begin
    if (in_row[COORD_W-1]) begin
      row_base = '0;
      row_frac = '0;
    end else if (RCMP_W'(row_ip) >= RCMP_W'(height_eff) - RCMP_W'(1)) begin
      row_base = ROW_W'(height_eff - HSIZE_W'(2));
      row_frac = WGT_W'(ONE);
    end else begin
      row_base = row_ip[ROW_W-1:0];
      row_frac = {1'b0, in_row[COORD_FRAC_BITS-1:0]};
    end
  end

  always_comb begin
    row_off_a   = RO_W'(ry1) * RO_W'(width_eff);
    row_off_b   = RO_W'(ry1n) * RO_W'(width_eff);
    addr_a_next = STORE_AW'(row_off_a + RO_W'(cx1));
    addr_b_next = STORE_AW'(row_off_b + RO_W'(cx1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= in_valid;
      end
      if (en2) begin
        out_valid <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      cmd1   <= in_cmd;
      waddr1 <= in_waddr;
      wdata1 <= in_wdata;
      cx1    <= col_base;
      ry1    <= row_base;
      ry1n   <= ROW_W'(row_base + ROW_W'(1));
      wx0_1  <= WGT_W'(ONE) - col_frac;
      wx1_1  <= col_frac;
      wy0_1  <= WGT_W'(ONE) - row_frac;
      wy1_1  <= row_frac;
    end
    if (en2) begin
      out_req.cmd    <= cmd1;
      out_req.waddr  <= waddr1;
      out_req.wdata  <= wdata1;
      out_req.addr_a <= addr_a_next;
      out_req.addr_b <= addr_b_next;
      out_req.wx0    <= wx0_1;
      out_req.wx1    <= wx1_1;
      out_req.wy0    <= wy0_1;
      out_req.wy1    <= wy1_1;
    end
  end

  `ASSERT_IMPLY(weights_sum_one, clk, rst, out_valid && out_req.cmd == CMD_SAMPLE, (out_req.wx0 + out_req.wx1 == WGT_W'(ONE)) && (out_req.wy0 + out_req.wy1 == WGT_W'(ONE)))

endmodule

/* rtl/bssw_store.sv */
// slice store: two copies, each split into even and odd banks, four reads a cycle while the output is not stalled
`include "assert_macros.svh"

module bssw_store (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  bssw_pkg::req_t in_req,
  output logic           out_valid,
  input  logic           out_ready,
  output bssw_pkg::nbr_t out_nbr
);
  import bssw_pkg::*;

  logic               en3;
  logic               we;
  logic               wbank;
  logic [BANK_AW-1:0] widx;
  logic [BANK_AW-1:0] a_hi;
  logic [BANK_AW-1:0] b_hi;
  logic [BANK_AW-1:0] a_even_idx;
  logic [BANK_AW-1:0] b_even_idx;

  logic [SAMPLE_W-1:0] a_even_q;
  logic [SAMPLE_W-1:0] a_odd_q;
  logic [SAMPLE_W-1:0] b_even_q;
  logic [SAMPLE_W-1:0] b_odd_q;

  logic             sel_a;
  logic             sel_b;
  logic [WGT_W-1:0] wx0_3;
  logic [WGT_W-1:0] wx1_3;
  logic [WGT_W-1:0] wy0_3;
  logic [WGT_W-1:0] wy1_3;

  assign en3      = !out_valid || out_ready;
  assign in_ready = en3;

  // writes land in both copies so each copy can serve one row of the pair
  assign we    = en3 && in_valid && in_req.cmd == CMD_WRITE
                 && ({1'b0, in_req.waddr} < (ADDR_W + 1)'(STORE_DEPTH));
  assign wbank = in_req.waddr[0];
  assign widx  = in_req.waddr[STORE_AW-1:1];

  // an odd base puts its right neighbor in the next even entry
  assign a_hi       = in_req.addr_a[STORE_AW-1:1];
  assign b_hi       = in_req.addr_b[STORE_AW-1:1];
  assign a_even_idx = a_hi + BANK_AW'(in_req.addr_a[0]);
  assign b_even_idx = b_hi + BANK_AW'(in_req.addr_b[0]);

  bssw_ram #(.WIDTH(SAMPLE_W), .DEPTH(BANK_DEPTH)) u_a_even (
    .clk(clk), .we(we && !wbank), .waddr(widx), .wdata(in_req.wdata),
    .re(en3), .raddr(a_even_idx), .rdata(a_even_q)
  );

  bssw_ram #(.WIDTH(SAMPLE_W), .DEPTH(BANK_DEPTH)) u_a_odd (
    .clk(clk), .we(we && wbank), .waddr(widx), .wdata(in_req.wdata),
    .re(en3), .raddr(a_hi), .rdata(a_odd_q)
  );

  bssw_ram #(.WIDTH(SAMPLE_W), .DEPTH(BANK_DEPTH)) u_b_even (
    .clk(clk), .we(we && !wbank), .waddr(widx), .wdata(in_req.wdata),
    .re(en3), .raddr(b_even_idx), .rdata(b_even_q)
  );

  bssw_ram #(.WIDTH(SAMPLE_W), .DEPTH(BANK_DEPTH)) u_b_odd (
    .clk(clk), .we(we && wbank), .waddr(widx), .wdata(in_req.wdata),
    .re(en3), .raddr(b_hi), .rdata(b_odd_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en3) begin
      out_valid <= in_valid && in_req.cmd == CMD_SAMPLE;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      sel_a <= in_req.addr_a[0];
      sel_b <= in_req.addr_b[0];
      wx0_3 <= in_req.wx0;
      wx1_3 <= in_req.wx1;
      wy0_3 <= in_req.wy0;
      wy1_3 <= in_req.wy1;
    end
  end

  always_comb begin
    out_nbr.s00 = sel_a ? a_odd_q : a_even_q;
    out_nbr.s01 = sel_a ? a_even_q : a_odd_q;
    out_nbr.s10 = sel_b ? b_odd_q : b_even_q;
    out_nbr.s11 = sel_b ? b_even_q : b_odd_q;
    out_nbr.wx0 = wx0_3;
    out_nbr.wx1 = wx1_3;
    out_nbr.wy0 = wy0_3;
    out_nbr.wy1 = wy1_3;
  end

  `ASSERT_NEXT(stall_holds_samples, clk, rst, out_valid && !out_ready, $stable(out_nbr))

endmodule

/* rtl/bssw_shade.sv */
// bilinear blend, window offset, gain scaling and saturation pipeline
`include "assert_macros.svh"

module bssw_shade (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  bssw_pkg::nbr_t                      in_nbr,
  input  logic signed [bssw_pkg::SAMPLE_W-1:0] window_low,
  input  logic [bssw_pkg::GAIN_W-1:0]         window_gain,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bssw_pkg::SHADE_W-1:0]        shade
);
  import bssw_pkg::*;

  logic e4, e5, e6, e7, e8, eo;
  logic v4, v5, v6, v7, v8;

  logic signed [PROD1_W-1:0] m0, m1, m2, m3;
  logic [WGT_W-1:0]          wy0_4, wy1_4, wy0_5, wy1_5;
  logic signed [HSUM_W-1:0]  top5, bot5;
  logic signed [PROD2_W-1:0] n0, n1;
  logic signed [DIFF_W-1:0]  low_ext;
  logic signed [DIFF_W-1:0]  d_next;
  logic                      pos7, pos8;
  logic [DU_W-1:0]           du7;
  logic [SCALE_W-1:0]        prod8;
  logic [HI_W-1:0]           hi;

  assign eo       = !out_valid || out_ready;
  assign e8       = !v8 || eo;
  assign e7       = !v7 || e8;
  assign e6       = !v6 || e7;
  assign e5       = !v5 || e6;
  assign e4       = !v4 || e5;
  assign in_ready = e4;

  // window_low scaled into the weight fraction of the blend
  assign low_ext = {{(DIFF_W - SAMPLE_W - 2 * COORD_FRAC_BITS){window_low[SAMPLE_W-1]}},
                    window_low, {(2 * COORD_FRAC_BITS){1'b0}}};
  assign d_next  = DIFF_W'(n0) + DIFF_W'(n1) - low_ext;
  assign hi      = prod8[SCALE_W-1:SHADE_SH];

  always_ff @(posedge clk) begin
    if (rst) begin
      v4        <= 1'b0;
      v5        <= 1'b0;
      v6        <= 1'b0;
      v7        <= 1'b0;
      v8        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (e4) v4 <= in_valid;
      if (e5) v5 <= v4;
      if (e6) v6 <= v5;
      if (e7) v7 <= v6;
      if (e8) v8 <= v7;
      if (eo) out_valid <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (e4) begin
      m0    <= $signed(in_nbr.s00) * $signed({1'b0, in_nbr.wx0});
      m1    <= $signed(in_nbr.s01) * $signed({1'b0, in_nbr.wx1});
      m2    <= $signed(in_nbr.s10) * $signed({1'b0, in_nbr.wx0});
      m3    <= $signed(in_nbr.s11) * $signed({1'b0, in_nbr.wx1});
      wy0_4 <= in_nbr.wy0;
      wy1_4 <= in_nbr.wy1;
    end
    if (e5) begin
      top5  <= HSUM_W'(m0) + HSUM_W'(m1);
      bot5  <= HSUM_W'(m2) + HSUM_W'(m3);
      wy0_5 <= wy0_4;
      wy1_5 <= wy1_4;
    end
    if (e6) begin
      n0 <= top5 * $signed({1'b0, wy0_5});
      n1 <= bot5 * $signed({1'b0, wy1_5});
    end
    if (e7) begin
      pos7 <= !d_next[DIFF_W-1] && (d_next != '0);
      du7  <= d_next[DU_W-1:0];
    end
    if (e8) begin
      pos8  <= pos7;
      prod8 <= SCALE_W'(du7) * SCALE_W'(window_gain);
    end
    if (eo) begin
      if (!pos8) begin
        shade <= '0;
      end else if (|hi[HI_W-1:SHADE_W]) begin
        shade <= '1;
      end else begin
        shade <= hi[SHADE_W-1:0];
      end
    end
  end

  `ASSERT_NEXT(reset_empties_output, clk, 1'b0, rst, !out_valid && !v8 && !v4)

endmodule

/* rtl/bilinear_slice_sampler_window.sv */
// top level of the bilinear slice sampler with intensity windowing
//
// s_axis carries one item per transaction. tuser is the command: a write
// stores sample_value at the flat address row * width_in_use + column, a
// sample request carries a column and a row coordinate with 8 fraction
// bits. Each request returns one 8-bit shade on m_axis, in request order;
// writes return nothing and take effect for every later request.
// Throughput: one item per cycle unless m_axis stalls, set by the four
// banked neighbor reads (two copies of the slice, each split into even
// and odd address banks).
// cfg_we writes the register cfg_index from cfg_data; write it
// only while no request is in flight. Sizes outside 2..512 act as clamped.
// Reset (rst, synchronous) empties the pipeline and loads the register
// defaults; store contents are undefined until written, with no clear pass.
// When m_axis stalls the pipeline closes its bubbles first, so s_axis keeps
// accepting until every stage holds an item, then tready drops.
module bilinear_slice_sampler_window (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // write_address[17:0], sample_value[33:18], coord_col[52:34], coord_row[71:53]
  input  logic [71:0]                          s_axis_tdata,
  // command[0]
  input  logic [0:0]                           s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // shade[7:0]
  output logic [bssw_pkg::SHADE_W-1:0]         m_axis_tdata,
  input  logic                                 cfg_we,
  input  logic [bssw_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [bssw_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import bssw_pkg::*;

  logic [SIZE_REG_W-1:0]      width_cfg;
  logic [SIZE_REG_W-1:0]      height_cfg;
  logic signed [SAMPLE_W-1:0] window_low;
  logic [GAIN_W-1:0]          window_gain;
  logic [WSIZE_W-1:0]         width_eff;
  logic [HSIZE_W-1:0]         height_eff;

  logic  front_valid, store_ready;
  req_t  front_req;
  logic  store_valid, shade_ready;
  nbr_t  store_nbr;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_cfg   <= SIZE_REG_W'(512);
      height_cfg  <= SIZE_REG_W'(512);
      window_low  <= '0;
      window_gain <= GAIN_W'(65536);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH_IN_USE:  width_cfg   <= cfg_data[SIZE_REG_W-1:0];
        REG_HEIGHT_IN_USE: height_cfg  <= cfg_data[SIZE_REG_W-1:0];
        REG_WINDOW_LOW:    window_low  <= cfg_data[SAMPLE_W-1:0];
        REG_WINDOW_GAIN:   window_gain <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_cfg < SIZE_REG_W'(2)) begin
      width_eff = WSIZE_W'(2);
    end else if (32'(width_cfg) > MAX_WIDTH) begin
      width_eff = WSIZE_W'(MAX_WIDTH);
    end else begin
      width_eff = WSIZE_W'(width_cfg);
    end
    if (height_cfg < SIZE_REG_W'(2)) begin
      height_eff = HSIZE_W'(2);
    end else if (32'(height_cfg) > MAX_HEIGHT) begin
      height_eff = HSIZE_W'(MAX_HEIGHT);
    end else begin
      height_eff = HSIZE_W'(height_cfg);
    end
  end

  bssw_front u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .in_cmd(s_axis_tuser[0]),
    .in_waddr(s_axis_tdata[17:0]),
    .in_wdata(s_axis_tdata[33:18]),
    .in_col(s_axis_tdata[52:34]),
    .in_row(s_axis_tdata[71:53]),
    .width_eff(width_eff),
    .height_eff(height_eff),
    .out_valid(front_valid),
    .out_ready(store_ready),
    .out_req(front_req)
  );

  bssw_store u_store (
    .clk(clk),
    .rst(rst),
    .in_valid(front_valid),
    .in_ready(store_ready),
    .in_req(front_req),
    .out_valid(store_valid),
    .out_ready(shade_ready),
    .out_nbr(store_nbr)
  );

  bssw_shade u_shade (
    .clk(clk),
    .rst(rst),
    .in_valid(store_valid),
    .in_ready(shade_ready),
    .in_nbr(store_nbr),
    .window_low(window_low),
    .window_gain(window_gain),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .shade(m_axis_tdata)
  );

endmodule

/* test/tb.sv */
// testbench for the bilinear slice sampler: directed table, then randomized slices and windows
`timescale 1ns / 1ps

module tb;
  import bssw_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 12;
  localparam logic [COORD_W-1:0] COORD_MIN = 19'h40000;
  localparam logic [COORD_W-1:0] COORD_MAX = 19'h3FFFF;
  localparam logic [COORD_W-1:0] COORD_NEG1 = 19'h7FFFF;

  typedef struct packed {
    logic                cmd;
    logic [ADDR_W-1:0]   waddr;
    logic [SAMPLE_W-1:0] sval;
    logic [COORD_W-1:0]  col;
    logic [COORD_W-1:0]  row;
    logic                has_ref;
    logic [SHADE_W-1:0]  ref_shade;
  } stim_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [71:0]            s_axis_tdata = '0;
  logic [0:0]             s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [SHADE_W-1:0]     m_axis_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // typed-in shade that travels with the current transaction
  logic               tx_has_ref = 1'b0;
  logic [SHADE_W-1:0] tx_ref_shade = '0;

  int tx_idle_odds = 0;
  int rx_idle_odds = 0;
  int rx_stall = 0;

  // mirror of the block: registers and slice contents
  logic [SIZE_REG_W-1:0] width_reg = 10'd512;
  logic [SIZE_REG_W-1:0] height_reg = 10'd512;
  logic [SAMPLE_W-1:0]   low_reg = '0;
  logic [GAIN_W-1:0]     gain_reg = 24'h010000;
  logic [SAMPLE_W-1:0]   slice_mem [STORE_DEPTH];

  logic [SHADE_W-1:0] shade_fifo [$];
  int writes_seen = 0;
  int requests_seen = 0;
  int shades_checked = 0;
  int failures = 0;
  int settings_run = 1;
  int idle_cycles = 0;

  bilinear_slice_sampler_window dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int clamp_extent(logic [SIZE_REG_W-1:0] raw, int limit);
    if (raw < 2) return 2;
    if (raw > limit) return limit;
    return int'(raw);
  endfunction

  // floor index and upper-neighbor weight along one axis
  function automatic void split_axis(input logic signed [COORD_W-1:0] c, input int extent,
                                     output int base, output int frac);
    int idx;
    if (c < 0) begin
      base = 0;
      frac = 0;
    end else begin
      idx = int'(c) >>> COORD_FRAC_BITS;
      if (idx >= extent - 1) begin
        base = extent - 2;
        frac = ONE;
      end else begin
        base = idx;
        frac = int'(c) & (ONE - 1);
      end
    end
  endfunction

  function automatic logic [SHADE_W-1:0] blend_shade(logic [COORD_W-1:0] col,
                                                     logic [COORD_W-1:0] row);
    int cols, rows, cx, fx, ry, fy, r0, r1;
    longint blend, diff, scaled;
    cols = clamp_extent(width_reg, MAX_WIDTH);
    rows = clamp_extent(height_reg, MAX_HEIGHT);
    split_axis($signed(col), cols, cx, fx);
    split_axis($signed(row), rows, ry, fy);
    r0 = ry * cols;
    r1 = (ry + 1) * cols;
    blend = longint'($signed(slice_mem[r0 + cx])) * (ONE - fx) * (ONE - fy)
          + longint'($signed(slice_mem[r0 + cx + 1])) * fx * (ONE - fy)
          + longint'($signed(slice_mem[r1 + cx])) * (ONE - fx) * fy
          + longint'($signed(slice_mem[r1 + cx + 1])) * fx * fy;
    diff = blend - longint'($signed(low_reg)) * (ONE * ONE);
    if (diff <= 0 || gain_reg == 0) return '0;
    scaled = (diff * longint'(gain_reg)) >>> (2 * COORD_FRAC_BITS + GAIN_FRAC);
    return (scaled > 255) ? 8'd255 : 8'(scaled);
  endfunction

  // scoreboard: compare shades, then fold in accepted items and register writes
  always @(posedge clk) begin : scoreboard
    logic [SHADE_W-1:0] want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (shade_fifo.size() == 0) begin
          $error("shade %0d arrived with no request pending", m_axis_tdata);
          failures++;
        end else begin
          want = shade_fifo.pop_front();
          shades_checked++;
          if (m_axis_tdata !== want) begin
            $error("shade: expected %0d, got %0d", want, m_axis_tdata);
            failures++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser[0] == CMD_WRITE) begin
          slice_mem[s_axis_tdata[17:0]] = s_axis_tdata[33:18];
          writes_seen++;
        end else begin
          want = tx_has_ref ? tx_ref_shade : blend_shade(s_axis_tdata[52:34], s_axis_tdata[71:53]);
          shade_fifo.push_back(want);
          requests_seen++;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_WIDTH_IN_USE:  width_reg = cfg_data[SIZE_REG_W-1:0];
          REG_HEIGHT_IN_USE: height_reg = cfg_data[SIZE_REG_W-1:0];
          REG_WINDOW_LOW:    low_reg = cfg_data[SAMPLE_W-1:0];
          REG_WINDOW_GAIN:   gain_reg = cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("no transaction for %0d cycles, %0d shades outstanding",
               idle_cycles, shade_fifo.size());
      $display("FAIL bilinear_slice_sampler_window");
      $finish;
    end
  end

  // shade receiver with random stall bursts
  always @(negedge clk) begin
    if (rx_stall > 0) begin
      m_axis_tready = 1'b0;
      rx_stall--;
    end else if (rx_idle_odds != 0 && $urandom_range(0, rx_idle_odds - 1) == 0) begin
      m_axis_tready = 1'b0;
      rx_stall = $urandom_range(0, 18);
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  // called just after a falling edge; returns just after a falling edge, once the item has been accepted
  task automatic send_item(input stim_t it);
    int gap;
    if (tx_idle_odds != 0 && $urandom_range(0, tx_idle_odds - 1) == 0) begin
      s_axis_tvalid = 1'b0;
      gap = $urandom_range(1, 19);
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {it.row, it.col, it.sval, it.waddr};
    s_axis_tuser = it.cmd;
    tx_has_ref = it.has_ref;
    tx_ref_shade = it.ref_shade;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    while (shade_fifo.size() != 0) @(negedge clk);
    // trailing writes may still be in the pipeline
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic stim_t make_write(int addr, logic [SAMPLE_W-1:0] value);
    stim_t it;
    it = '0;
    it.cmd = CMD_WRITE;
    it.waddr = ADDR_W'(addr);
    it.sval = value;
    it.col = COORD_W'($urandom);
    it.row = COORD_W'($urandom);
    return it;
  endfunction

  function automatic stim_t make_request(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
    stim_t it;
    it = '0;
    it.cmd = CMD_SAMPLE;
    it.waddr = ADDR_W'($urandom);
    it.sval = SAMPLE_W'($urandom);
    it.col = col;
    it.row = row;
    return it;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample(logic [SAMPLE_W-1:0] low, int span);
    int v;
    if ($urandom_range(0, 1) == 1) return SAMPLE_W'($urandom);
    v = int'($signed(low)) + int'($urandom_range(0, span));
    if (v > 32767) v = 32767;
    return SAMPLE_W'(v);
  endfunction

  // interior points, clamp region above, negatives, raw bits and grid points
  function automatic logic [COORD_W-1:0] pick_coord(int extent);
    int c;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: c = $urandom_range(0, (extent - 1) * ONE - 1);
      5, 6:          c = $urandom_range((extent - 1) * ONE, (extent + 2) * ONE);
      7:             c = -int'($urandom_range(1, 2 * ONE));
      8:             c = $urandom;
      default:       c = $urandom_range(0, extent) * ONE;
    endcase
    return COORD_W'(c);
  endfunction

  function automatic logic [SIZE_REG_W-1:0] pick_extent();
    case ($urandom_range(0, 7))
      0:       return SIZE_REG_W'($urandom_range(0, 1));
      1:       return SIZE_REG_W'($urandom_range(13, 40));
      default: return SIZE_REG_W'($urandom_range(2, 12));
    endcase
  endfunction

  // program the registers, fill the slice region, then mix requests and writes
  task automatic run_setting(input logic [SIZE_REG_W-1:0] w_raw,
                             input logic [SIZE_REG_W-1:0] h_raw,
                             input logic [SAMPLE_W-1:0] low, input logic [GAIN_W-1:0] gain,
                             input int n_items, input int tx_odds, input int rx_odds);
    int cols, rows, span, pick;
    stim_t it;
    wait_idle();
    write_register(REG_WIDTH_IN_USE, {14'($urandom), w_raw});
    write_register(REG_HEIGHT_IN_USE, {14'($urandom), h_raw});
    write_register(REG_WINDOW_LOW, {8'($urandom), low});
    write_register(REG_WINDOW_GAIN, gain);
    settings_run++;
    tx_idle_odds = tx_odds;
    rx_idle_odds = rx_odds;
    cols = clamp_extent(w_raw, MAX_WIDTH);
    rows = clamp_extent(h_raw, MAX_HEIGHT);
    span = (gain == 0) ? 65535 : (255 * 65536) / int'(gain) + 1;
    if (span > 65535) span = 65535;
    for (int a = 0; a < cols * rows; a++)
      send_item(make_write(a, pick_sample(low, span)));
    for (int n = 0; n < n_items; n++) begin
      pick = $urandom_range(0, 9);
      if (pick < 6)
        it = make_request(pick_coord(cols), pick_coord(rows));
      else if (pick < 9)
        it = make_write($urandom_range(0, cols * rows - 1), pick_sample(low, span));
      else
        it = make_write(int'(ADDR_W'($urandom)), SAMPLE_W'($urandom));
      send_item(it);
    end
  endtask

  initial begin : stimulus
    stim_t directed_rows [24];
    logic [GAIN_W-1:0] gain;
    // reset registers: 512 x 512, low 0, unit gain, so shade is the floored blend
    directed_rows = '{
      '{CMD_WRITE,  18'd0,      16'd100,  19'd0,      19'd0,      1'b0, 8'd0},
      '{CMD_WRITE,  18'd1,      16'd200,  19'd0,      19'd0,      1'b0, 8'd0},
      '{CMD_WRITE,  18'd512,    16'd300,  19'd0,      19'd0,      1'b0, 8'd0},
      '{CMD_WRITE,  18'd513,    16'h8000, 19'd0,      19'd0,      1'b0, 8'd0},
      '{CMD_SAMPLE, 18'd0,      16'd0,    19'd0,      19'd0,      1'b1, 8'd100},
      '{CMD_SAMPLE, 18'd0,      16'd0,    COORD_MIN,  COORD_NEG1, 1'b1, 8'd100},
      '{CMD_SAMPLE, 18'd0,      16'd0,    19'd128,    19'd0,      1'b1, 8'd150},
      '{CMD_SAMPLE, 18'd0,      16'd0,    19'd255,    19'd255,    1'b0, 8'd0},
      '{CMD_WRITE,  18'd261630, 16'd0,    19'd0,      19'd0,      1'b0, 8'd0},
      '{CMD_WRITE,  18'd261631, 16'd0,    19'd0,      19'd0,      1'b0, 8'd0},
      '{CMD_WRITE,  18'd262142, 16'd0,    19'd0,      19'd0,      1'b0, 8'd0},
      '{CMD_WRITE,  18'd262143, 16'h7FFF, 19'd0,      19'd0,      1'b0, 8'd0},
      '{CMD_SAMPLE, 18'd0,      16'd0,    COORD_MAX,  COORD_MAX,  1'b1, 8'd255},
      '{CMD_WRITE,  18'd510,    16'd0,    19'd0,      19'd0,      1'b0, 8'd0},
      '{CMD_WRITE,  18'd511,    16'd50,   19'd0,      19'd0,      1'b0, 8'd0},
      '{CMD_WRITE,  18'd1022,   16'd0,    19'd0,      19'd0,      1'b0, 8'd0},
      '{CMD_WRITE,  18'd1023,   16'd0,    19'd0,      19'd0,      1'b0, 8'd0},
      '{CMD_SAMPLE, 18'd0,      16'd0,    COORD_MAX,  COORD_MIN,  1'b1, 8'd50},
      '{CMD_SAMPLE, 18'd0,      16'd0,    19'd130816, COORD_NEG1, 1'b1, 8'd50},
      '{CMD_SAMPLE, 18'd0,      16'd0,    19'd130688, 19'd0,      1'b0, 8'd0},
      '{CMD_WRITE,  18'd0,      16'hFFFB, 19'd0,      19'd0,      1'b0, 8'd0},
      '{CMD_SAMPLE, 18'd0,      16'd0,    19'd0,      19'd0,      1'b1, 8'd0},
      '{CMD_SAMPLE, 18'd0,      16'd0,    19'd255,    19'd0,      1'b0, 8'd0},
      '{CMD_SAMPLE, 18'd0,      16'd0,    19'd0,      19'd128,    1'b0, 8'd0}
    };
    repeat (11) @(negedge clk);
    rst = 1'b0;
    tx_idle_odds = 5;
    rx_idle_odds = 5;
    foreach (directed_rows[i]) send_item(directed_rows[i]);

    // zero gain, saturating gain, and both size clamps
    run_setting(10'd2, 10'd2, 16'h7FFF, 24'd0, 100, 4, 6);
    run_setting(10'd0, 10'd1, 16'h8000, 24'hFFFFFF, 100, 0, 3);
    run_setting(10'd1023, 10'd0, 16'h0000, 24'h010000, 80, 8, 0);
    run_setting(10'd2, 10'd1023, 16'($urandom), 24'h00FF00, 80, 3, 3);
    for (int k = 0; k < 6; k++) begin
      if ($urandom_range(0, 3) == 0)
        gain = GAIN_W'($urandom);
      else
        gain = GAIN_W'((255 * 65536) / $urandom_range(1, 65535));
      run_setting(pick_extent(), pick_extent(), 16'($urandom), gain, 100,
                  3 * $urandom_range(0, 3), 3 * $urandom_range(0, 3));
    end
    // closing stretch at full rate on both sides
    run_setting(pick_extent(), pick_extent(), 16'($urandom),
                GAIN_W'((255 * 65536) / $urandom_range(1, 65535)), 150, 0, 0);
    wait_idle();
    repeat (2 * DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d slice writes and %0d shade requests over %0d register settings",
             writes_seen, requests_seen, settings_run);
    $display("%0d shades compared, %0d failures", shades_checked, failures);
    if (failures == 0 && shade_fifo.size() == 0) begin
      $display("PASS bilinear_slice_sampler_window");
    end else begin
      $display("FAIL bilinear_slice_sampler_window");
    end
    $finish;
  end

endmodule
